// ----- hw/rtl/rfc5987_pkg.sv -----
// Package for the RFC 5987 ext-value decoder: codes, label tables and helpers.
`timescale 1ns / 1ps

package rfc5987_pkg;

  // Parse phase of the ext-value text
  typedef enum logic [1:0] {
    PH_CHARSET = 2'd0,
    PH_LANG    = 2'd1,
    PH_VALUE   = 2'd2
  } phase_t;

  // Percent-escape progress
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HI   = 2'd1,
    ESC_LO   = 2'd2,
    ESC_BAD  = 2'd3
  } esc_t;

  // Final status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MISSING = 3'd1,
    ST_EXTRA   = 3'd2,
    ST_CHARSET = 3'd3,
    ST_ESCAPE  = 3'd4,
    ST_CONTROL = 3'd5
  } status_t;

  // Sticky error flag bit positions
  localparam int unsigned FL_MISSING = 0;
  localparam int unsigned FL_EXTRA   = 1;
  localparam int unsigned FL_CHARSET = 2;
  localparam int unsigned FL_ESCAPE  = 3;
  localparam int unsigned FL_CONTROL = 4;
  localparam int unsigned FL_W       = 5;

  localparam int unsigned UTF8_LEN   = 5;
  localparam int unsigned LATIN1_LEN = 10;

  // Result buffer entries
  localparam int unsigned DEPTH = 4;

  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] LEAD_BASE  = 8'hC0;
  localparam logic [7:0] CONT_BASE  = 8'h80;
  localparam logic [7:0] LOW6_MASK  = 8'h3F;

  // One result beat
  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       last;
    status_t    status;
  } item_t;

  // "utf-8", position by position
  function automatic logic [7:0] utf8_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h75;
      4'd1:    c = 8'h74;
      4'd2:    c = 8'h66;
      4'd3:    c = 8'h2D;
      4'd4:    c = 8'h38;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "iso-8859-1", position by position
  function automatic logic [7:0] latin1_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h69;
      4'd1:    c = 8'h73;
      4'd2:    c = 8'h6F;
      4'd3:    c = 8'h2D;
      4'd4:    c = 8'h38;
      4'd5:    c = 8'h38;
      4'd6:    c = 8'h35;
      4'd7:    c = 8'h39;
      4'd8:    c = 8'h2D;
      4'd9:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c + 8'd32;
    return r;
  endfunction

  // Returns {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) r = {1'b1, 4'(c - 8'h30)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'h57)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

// ----- hw/rtl/rfc5987_ext_value_decoder_unit.sv -----
// Top level of the RFC 5987 ext-value decoder: parser state and result buffer.
`timescale 1ns / 1ps

// Streaming decoder for an RFC 5987 ext-value (charset'language'value).
// Input channel in_*: one text byte per beat, in_tlast on the final byte.
// Output channel out_*: decoded bytes (out_tuser = 1) in order, then one
// status beat (out_tuser = 0, out_tlast = 1) per value; a nonzero status
// means the bytes already sent for that value are to be dropped.
// An accepted byte is parsed in the cycle it is taken and its results are
// written into a four-entry result buffer; being registered, a result
// reaches out_* no earlier than the cycle after its byte is taken.
// in_tready is high while the buffer holds at most one beat, so with the
// receiver ready one input byte is taken every cycle while each byte makes
// a single beat. A byte makes up to three beats (a Latin-1 high octet gives
// two, the last byte adds status); the output port drains one beat a cycle
// while out_tready is high, so in_tready is low while the extra beats
// drain; this is set by the single output port.
// Reset (rst_n low, synchronous) empties the buffer and returns the parser
// to the charset phase. When the receiver stalls, the buffer fills and
// in_tready drops; no beat is lost or repeated.
module rfc5987_ext_value_decoder_unit
  import rfc5987_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        out_tuser,  // byte_valid
  output logic        out_tlast   // is_last
);

  // Parser state
  phase_t          phase_r, phase_nxt;
  logic [1:0]      qcnt_r, qcnt_nxt;
  logic [3:0]      lpos_r, lpos_nxt;
  logic            utf8_r, utf8_nxt;
  logic            latin1_r, latin1_nxt;
  esc_t            esc_r, esc_nxt;
  logic [3:0]      hnib_r, hnib_nxt;
  logic [FL_W-1:0] flags_r, flags_nxt;

  // Result buffer
  item_t      buf_r [DEPTH];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;

  item_t      items [3];
  logic [1:0] n_items;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (cnt_r <= 3'd1);

  // Per-byte parse: next state and up to three result beats
  always_comb begin
    logic [7:0] lc;
    logic [4:0] hx;
    logic       emit;
    logic [7:0] oct;
    status_t    st;
    lc = lower_ascii(in_tdata);
    hx = hex_digit(in_tdata);
    emit = 1'b0;
    oct = in_tdata;
    st = ST_OK;
    phase_nxt = phase_r;
    qcnt_nxt = qcnt_r;
    lpos_nxt = lpos_r;
    utf8_nxt = utf8_r;
    latin1_nxt = latin1_r;
    esc_nxt = esc_r;
    hnib_nxt = hnib_r;
    flags_nxt = flags_r;
    n_items = 2'd0;
    for (int i = 0; i < 3; i++) begin
      items[i] = '{data: 8'd0, bvalid: 1'b0, last: 1'b0, status: ST_OK};
    end

    if (in_tdata == CH_QUOTE) begin
      // quote: closes charset, then language, else an extra quote
      if (qcnt_r == 2'd0) begin
        utf8_nxt = utf8_r && (lpos_r == 4'(UTF8_LEN));
        latin1_nxt = latin1_r && (lpos_r == 4'(LATIN1_LEN));
        if (!utf8_nxt && !latin1_nxt) flags_nxt[FL_CHARSET] = 1'b1;
        phase_nxt = PH_LANG;
      end else if (qcnt_r == 2'd1) begin
        phase_nxt = PH_VALUE;
      end else begin
        flags_nxt[FL_EXTRA] = 1'b1;
      end
      if (qcnt_r != 2'd3) qcnt_nxt = qcnt_r + 2'd1;
    end else if (phase_r == PH_CHARSET) begin
      // label match, case-folded
      if (lpos_r >= 4'(UTF8_LEN) || utf8_char(lpos_r) != lc) utf8_nxt = 1'b0;
      if (lpos_r >= 4'(LATIN1_LEN) || latin1_char(lpos_r) != lc) latin1_nxt = 1'b0;
      if (lpos_r != 4'd15) lpos_nxt = lpos_r + 4'd1;
    end else if (phase_r == PH_VALUE) begin
      // percent decoding
      case (esc_r)
        ESC_NONE: begin
          if (in_tdata == CH_PERCENT) esc_nxt = ESC_HI;
          else emit = 1'b1;
        end
        ESC_HI: begin
          if (!hx[4]) begin
            flags_nxt[FL_ESCAPE] = 1'b1;
            esc_nxt = ESC_BAD;
          end else begin
            hnib_nxt = hx[3:0];
            esc_nxt = ESC_LO;
          end
        end
        ESC_LO: begin
          if (!hx[4]) flags_nxt[FL_ESCAPE] = 1'b1;
          else begin
            emit = 1'b1;
            oct = {hnib_r, hx[3:0]};
          end
          esc_nxt = ESC_NONE;
        end
        default: begin
          if (!hx[4]) flags_nxt[FL_ESCAPE] = 1'b1;
          esc_nxt = ESC_NONE;
        end
      endcase
    end

    // octet out, widened to two bytes under Latin-1 when its top bit is set
    if (emit) begin
      if (latin1_r && oct[7]) begin
        items[0].data = LEAD_BASE | {6'd0, oct[7:6]};
        items[0].bvalid = 1'b1;
        items[1].data = CONT_BASE | (oct & LOW6_MASK);
        items[1].bvalid = 1'b1;
        n_items = 2'd2;
      end else begin
        if (oct == 8'h0D || oct == 8'h0A || oct == 8'h00) flags_nxt[FL_CONTROL] = 1'b1;
        items[0].data = oct;
        items[0].bvalid = 1'b1;
        n_items = 2'd1;
      end
    end

    // end of value: status beat and state back to reset values
    if (in_tlast) begin
      if (qcnt_nxt < 2'd2) flags_nxt[FL_MISSING] = 1'b1;
      if (esc_nxt != ESC_NONE) flags_nxt[FL_ESCAPE] = 1'b1;
      if (flags_nxt[FL_MISSING]) st = ST_MISSING;
      else if (flags_nxt[FL_EXTRA]) st = ST_EXTRA;
      else if (flags_nxt[FL_CHARSET]) st = ST_CHARSET;
      else if (flags_nxt[FL_ESCAPE]) st = ST_ESCAPE;
      else if (flags_nxt[FL_CONTROL]) st = ST_CONTROL;
      items[n_items] = '{data: 8'd0, bvalid: 1'b0, last: 1'b1, status: st};
      n_items = n_items + 2'd1;
      phase_nxt = PH_CHARSET;
      qcnt_nxt = 2'd0;
      lpos_nxt = 4'd0;
      utf8_nxt = 1'b1;
      latin1_nxt = 1'b1;
      esc_nxt = ESC_NONE;
      hnib_nxt = 4'd0;
      flags_nxt = '0;
    end
  end

  // Parser state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CHARSET;
      qcnt_r <= 2'd0;
      lpos_r <= 4'd0;
      utf8_r <= 1'b1;
      latin1_r <= 1'b1;
      esc_r <= ESC_NONE;
      hnib_r <= 4'd0;
      flags_r <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      qcnt_r <= qcnt_nxt;
      lpos_r <= lpos_nxt;
      utf8_r <= utf8_nxt;
      latin1_r <= latin1_nxt;
      esc_r <= esc_nxt;
      hnib_r <= hnib_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Result buffer pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (in_acc) wr_ptr_r <= wr_ptr_r + n_items;
      if (out_acc) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + (in_acc ? {1'b0, n_items} : 3'd0) - {2'd0, out_acc};
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_items) buf_r[wr_ptr_r + 2'(i)] <= items[i];
      end
    end
  end

  // Output beat
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {5'd0, buf_r[rd_ptr_r].status, buf_r[rd_ptr_r].data};
  assign out_tuser  = buf_r[rd_ptr_r].bvalid;
  assign out_tlast  = buf_r[rd_ptr_r].last;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(DEPTH))
    else $error("result buffer overflow");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> phase_r == PH_CHARSET && esc_r == ESC_NONE && flags_r == '0)
    else $error("parser state not cleared after final byte");

  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser && out_tdata[7:0] == 8'd0)
    else $error("status beat carries data");

  a_data_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser && out_tdata[10:8] == ST_OK)
    else $error("data beat carries status");

  a_no_emit_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r != PH_VALUE && !in_tlast |-> n_items == 2'd0)
    else $error("byte emitted before value part");
`endif

endmodule
